[rtl/v3alu_pkg.sv]
// shared types for the three-component vector alu
package v3alu_pkg;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_SCALE = 4'd2,
		OP_ADDS  = 4'd3,
		OP_MUL   = 4'd4,
		OP_DOT   = 4'd5,
		OP_CROSS = 4'd6,
		OP_NORM2 = 4'd7,
		OP_NORM  = 4'd8,
		OP_UNIT  = 4'd9
	} op_t;

endpackage

[rtl/v3alu_sqrt.sv]
// pipelined rounded integer square root, one root bit per stage
module v3alu_sqrt #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic [2*W-1:0] s,
	output logic [W:0]     root
);

	logic [2*W-1:0] rem_q  [W];
	logic [W-1:0]   root_q [W];
	logic [W:0]     rnd_q;

	for (genvar k = 0; k < W; k++) begin : g_stage
		localparam int B = W - 1 - k;
		logic [2*W-1:0] rin;
		logic [W-1:0]   qin;
		logic [2*W:0]   trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign rin = s;
			assign qin = '0;
		end else begin : g_next
			assign rin = rem_q[k-1];
			assign qin = root_q[k-1];
		end

		// (r + 2^b)^2 - r^2
		assign trial = ((2*W+1)'(qin) << (B + 1)) + ((2*W+1)'(1) << (2 * B));
		assign ge    = {1'b0, rin} >= trial;

		always_ff @(posedge clk) begin
			rem_q[k]  <= ge ? (rin - trial[2*W-1:0]) : rin;
			root_q[k] <= ge ? (qin | (W'(1) << B)) : qin;
		end
	end

	// round to nearest: bump when remainder exceeds the root
	always_ff @(posedge clk) begin
		rnd_q <= {1'b0, root_q[W-1]} + (W+1)'(rem_q[W-1] > (2*W)'(root_q[W-1]));
	end

	assign root = rnd_q;

endmodule

[rtl/v3alu_div.sv]
// pipelined restoring divider, one quotient bit per stage
module v3alu_div #(
	parameter int DW = 34,
	parameter int QB = 18
) (
	input  logic             clk,
	input  logic [DW+QB-1:0] n,
	input  logic [DW-1:0]    d,
	output logic [QB-1:0]    q
);

	localparam int CW = DW + QB;

	logic [CW-1:0] rem_q [QB];
	logic [QB-1:0] quo_q [QB];
	logic [DW-1:0] den_q [QB];

	for (genvar k = 0; k < QB; k++) begin : g_stage
		localparam int B = QB - 1 - k;
		logic [CW-1:0] rin;
		logic [QB-1:0] qin;
		logic [DW-1:0] din;
		logic [CW-1:0] sh;
		logic          ge;

		if (k == 0) begin : g_first
			assign rin = n;
			assign qin = '0;
			assign din = d;
		end else begin : g_next
			assign rin = rem_q[k-1];
			assign qin = quo_q[k-1];
			assign din = den_q[k-1];
		end

		assign sh = CW'(din) << B;
		assign ge = rin >= sh;

		always_ff @(posedge clk) begin
			rem_q[k] <= ge ? (rin - sh) : rin;
			quo_q[k] <= ge ? (qin | (QB'(1) << B)) : qin;
			den_q[k] <= din;
		end
	end

	assign q = quo_q[QB-1];

endmodule

[rtl/vector3_alu_core.sv]
// three-component vector alu on signed fixed-point words, fully pipelined
//
// usage: drive operation, u, v and scalar_in and raise start; busy stays low,
// so an item is taken on every clock edge with start high. each item gives
// exactly one result, shown on res_x/res_y/res_z/res_scalar with saturated and
// zero_vector for one cycle while done is high. there is no output backpressure.
// done follows the accepting edge by a delay that is the same for every
// operation (at the default Q16.16 and at any other format), so results
// leave in the order the items came in. throughput is one item per cycle.
// the delay is set by the square root pipeline (one root bit per stage) and
// the three lane dividers of the unit vector (one quotient bit per stage).
// products use two WORD_BITS x WORD_BITS multipliers per lane in one stage.
// reset clears the valid bits only; items in flight are dropped and done
// stays low until new items arrive at the end of the pipeline.
module vector3_alu_core #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         operation,
	input  logic signed [31:0] u_x,
	input  logic signed [31:0] u_y,
	input  logic signed [31:0] u_z,
	input  logic signed [31:0] v_x,
	input  logic signed [31:0] v_y,
	input  logic signed [31:0] v_z,
	input  logic signed [31:0] scalar_in,
	output logic               done,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic signed [31:0] res_z,
	output logic signed [31:0] res_scalar,
	output logic               saturated,
	output logic               zero_vector
);

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int SW = 2 * W + 2;
	localparam int XW = 2 * W + 3;
	localparam int QB = F + 2;
	localparam int DW = W + 2;
	localparam int CW = DW + QB;
	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};

	localparam logic signed [SW-1:0] HALF   = SW'(1) << (F - 1);
	localparam logic signed [XW-1:0] SAT_HI = (XW'(1) << (W - 1)) - XW'(1);
	localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

	typedef struct packed {
		logic           f;
		logic [W-1:0]   v;
	} sat_t;

	typedef struct packed {
		v3alu_pkg::op_t     op;
		logic [2:0][W:0]    asum;
		logic [2:0][W-1:0]  umag;
		logic [2:0]         usgn;
		logic               uzero;
	} carry_t;

	typedef struct packed {
		v3alu_pkg::op_t     op;
		logic [2:0][W-1:0]  r;
		logic [W-1:0]       sc;
		logic               sf;
		logic               uzero;
		logic [2:0]         usgn;
		logic [2:0][W-1:0]  umag;
	} sidea_t;

	typedef struct packed {
		logic [2:0][W-1:0]  r;
		logic [W-1:0]       sc;
		logic               sf;
		logic               zf;
		logic               unit;
		logic [2:0]         usgn;
	} sideb_t;

	function automatic sat_t sat_fn(input logic signed [XW-1:0] x);
		sat_t r;
		if (x > SAT_HI) begin
			r.f = 1'b1;
			r.v = SAT_HI[W-1:0];
		end else if (x < SAT_LO) begin
			r.f = 1'b1;
			r.v = SAT_LO[W-1:0];
		end else begin
			r.f = 1'b0;
			r.v = x[W-1:0];
		end
		return r;
	endfunction

	// operands from the low word bits of each field
	logic signed [W-1:0] u_w [3];
	logic signed [W-1:0] v_w [3];
	logic signed [W-1:0] t_w;

	assign u_w[0] = W'($unsigned(u_x));
	assign u_w[1] = W'($unsigned(u_y));
	assign u_w[2] = W'($unsigned(u_z));
	assign v_w[0] = W'($unsigned(v_x));
	assign v_w[1] = W'($unsigned(v_y));
	assign v_w[2] = W'($unsigned(v_z));
	assign t_w    = W'($unsigned(scalar_in));

	assign busy = 1'b0;

	// stage 1: route operands to the multipliers, plain adds
	logic signed [W-1:0] a1_c [3];
	logic signed [W-1:0] b1_c [3];
	logic signed [W-1:0] a2_c [3];
	logic signed [W-1:0] b2_c [3];
	carry_t              c_c;

	always_comb begin
		c_c.op = v3alu_pkg::op_t'(operation);
		for (int i = 0; i < 3; i++) begin
			a1_c[i] = '0;
			b1_c[i] = '0;
			a2_c[i] = '0;
			b2_c[i] = '0;
			c_c.asum[i] = '0;
			c_c.usgn[i] = u_w[i][W-1];
			c_c.umag[i] = u_w[i][W-1] ? (~u_w[i] + W'(1)) : u_w[i];
			case (c_c.op)
				v3alu_pkg::OP_ADD: begin
					c_c.asum[i] = (W+1)'(u_w[i]) + (W+1)'(v_w[i]);
				end
				v3alu_pkg::OP_SUB: begin
					c_c.asum[i] = (W+1)'(u_w[i]) - (W+1)'(v_w[i]);
				end
				v3alu_pkg::OP_ADDS: begin
					c_c.asum[i] = (W+1)'(u_w[i]) + (W+1)'(t_w);
				end
				v3alu_pkg::OP_SCALE: begin
					a1_c[i] = u_w[i];
					b1_c[i] = t_w;
				end
				v3alu_pkg::OP_MUL, v3alu_pkg::OP_DOT: begin
					a1_c[i] = u_w[i];
					b1_c[i] = v_w[i];
				end
				v3alu_pkg::OP_NORM2, v3alu_pkg::OP_NORM, v3alu_pkg::OP_UNIT: begin
					a1_c[i] = u_w[i];
					b1_c[i] = u_w[i];
				end
				v3alu_pkg::OP_CROSS: begin
					a1_c[i] = u_w[NXT[i]];
					b1_c[i] = v_w[PRV[i]];
					a2_c[i] = u_w[PRV[i]];
					b2_c[i] = v_w[NXT[i]];
				end
				default: begin
				end
			endcase
		end
		c_c.uzero = (u_w[0] == '0) && (u_w[1] == '0) && (u_w[2] == '0);
	end

	logic                v_s1, v_s2, v_s3, v_s4;
	carry_t              c_s1, c_s2, c_s3, c_s4;
	logic signed [W-1:0] a1_s1 [3];
	logic signed [W-1:0] b1_s1 [3];
	logic signed [W-1:0] a2_s1 [3];
	logic signed [W-1:0] b2_s1 [3];
	logic signed [2*W-1:0] ma_s2 [3];
	logic signed [2*W-1:0] mb_s2 [3];
	logic signed [SW-1:0]  p_s3  [3];
	logic signed [SW-1:0]  pr_s4 [3];
	logic signed [SW-1:0]  ssum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		c_s1 <= c_c;
		c_s2 <= c_s1;
		c_s3 <= c_s2;
		c_s4 <= c_s3;
		for (int i = 0; i < 3; i++) begin
			a1_s1[i] <= a1_c[i];
			b1_s1[i] <= b1_c[i];
			a2_s1[i] <= a2_c[i];
			b2_s1[i] <= b2_c[i];
			ma_s2[i] <= a1_s1[i] * b1_s1[i];
			mb_s2[i] <= a2_s1[i] * b2_s1[i];
			p_s3[i]  <= SW'(ma_s2[i]) - SW'(mb_s2[i]);
			pr_s4[i] <= (p_s3[i] + HALF) >>> F;
		end
		ssum_s4 <= p_s3[0] + p_s3[1] + p_s3[2];
	end

	// stage 5: round and saturate everything that does not need the root
	logic signed [SW-1:0] sr_c;
	sidea_t               se_c;

	always_comb begin
		sat_t st;
		sr_c     = (ssum_s4 + HALF) >>> F;
		se_c.op    = c_s4.op;
		se_c.r     = '0;
		se_c.sc    = '0;
		se_c.sf    = 1'b0;
		se_c.uzero = c_s4.uzero;
		se_c.usgn  = c_s4.usgn;
		se_c.umag  = c_s4.umag;
		st         = '0;
		case (c_s4.op)
			v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB, v3alu_pkg::OP_ADDS: begin
				for (int i = 0; i < 3; i++) begin
					st = sat_fn(XW'($signed(c_s4.asum[i])));
					se_c.r[i] = st.v;
					se_c.sf   = se_c.sf | st.f;
				end
			end
			v3alu_pkg::OP_SCALE, v3alu_pkg::OP_MUL, v3alu_pkg::OP_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					st = sat_fn(XW'(pr_s4[i]));
					se_c.r[i] = st.v;
					se_c.sf   = se_c.sf | st.f;
				end
			end
			v3alu_pkg::OP_DOT, v3alu_pkg::OP_NORM2: begin
				st      = sat_fn(XW'(sr_c));
				se_c.sc = st.v;
				se_c.sf = st.f;
			end
			default: begin
			end
		endcase
	end

	logic [W:0] root;

	v3alu_sqrt #(
		.W(W)
	) u_sqrt (
		.clk  (clk),
		.s    (ssum_s4[2*W-1:0]),
		.root (root)
	);

	// side data waits here while the root is formed
	sidea_t     sa_s5 [W+1];
	logic [W:0] sav_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sav_s5 <= '0;
		end else begin
			sav_s5 <= {sav_s5[W-1:0], v_s4};
		end
	end

	always_ff @(posedge clk) begin
		sa_s5[0] <= se_c;
		for (int k = 1; k <= W; k++) begin
			sa_s5[k] <= sa_s5[k-1];
		end
	end

	// root ready: norm result and divider operands
	sidea_t        ta;
	sideb_t        sb_c;
	logic [CW-1:0] dn_c [3];
	logic [DW-1:0] dd_c;

	assign ta = sa_s5[W];

	always_comb begin
		sat_t st;
		sb_c.r    = ta.r;
		sb_c.sc   = ta.sc;
		sb_c.sf   = ta.sf;
		sb_c.zf   = (ta.op == v3alu_pkg::OP_UNIT) && ta.uzero;
		sb_c.unit = (ta.op == v3alu_pkg::OP_UNIT) && !ta.uzero;
		sb_c.usgn = ta.usgn;
		st        = sat_fn(XW'($signed({1'b0, root})));
		if (ta.op == v3alu_pkg::OP_NORM) begin
			sb_c.sc = st.v;
			sb_c.sf = st.f;
		end
		// |u| * 2^(F+1) + n over 2n rounds |u| * 2^F / n to nearest
		for (int i = 0; i < 3; i++) begin
			dn_c[i] = (CW'(ta.umag[i]) << (F + 1)) + CW'(root);
		end
		dd_c = DW'(root) << 1;
	end

	logic [QB-1:0] q [3];

	for (genvar i = 0; i < 3; i++) begin : g_div
		v3alu_div #(
			.DW(DW),
			.QB(QB)
		) u_div (
			.clk (clk),
			.n   (dn_c[i]),
			.d   (dd_c),
			.q   (q[i])
		);
	end

	sideb_t        sb_s6 [QB];
	logic [QB-1:0] sbv_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sbv_s6 <= '0;
		end else begin
			sbv_s6 <= {sbv_s6[QB-2:0], sav_s5[W]};
		end
	end

	always_ff @(posedge clk) begin
		sb_s6[0] <= sb_c;
		for (int k = 1; k < QB; k++) begin
			sb_s6[k] <= sb_s6[k-1];
		end
	end

	// final: sign and saturate the unit vector, pick the result
	sideb_t               tb;
	logic [2:0][W-1:0]    fr_c;
	logic                 fs_c;

	assign tb = sb_s6[QB-1];

	always_comb begin
		sat_t                 st;
		logic signed [XW-1:0] qx;
		fr_c = tb.r;
		fs_c = tb.sf;
		st   = '0;
		qx   = '0;
		if (tb.unit) begin
			for (int i = 0; i < 3; i++) begin
				qx = XW'($signed({1'b0, q[i]}));
				if (tb.usgn[i]) begin
					qx = -qx;
				end
				st      = sat_fn(qx);
				fr_c[i] = st.v;
				fs_c    = fs_c | st.f;
			end
		end
	end

	logic               done_q;
	logic signed [31:0] res_x_q, res_y_q, res_z_q, res_scalar_q;
	logic               saturated_q, zero_vector_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= sbv_s6[QB-1];
		end
	end

	always_ff @(posedge clk) begin
		res_x_q       <= 32'($signed(fr_c[0]));
		res_y_q       <= 32'($signed(fr_c[1]));
		res_z_q       <= 32'($signed(fr_c[2]));
		res_scalar_q  <= 32'($signed(tb.sc));
		saturated_q   <= fs_c;
		zero_vector_q <= tb.zf;
	end

	assign done        = done_q;
	assign res_x       = res_x_q;
	assign res_y       = res_y_q;
	assign res_z       = res_z_q;
	assign res_scalar  = res_scalar_q;
	assign saturated   = saturated_q;
	assign zero_vector = zero_vector_q;

endmodule
